// File: hdl/wsi_pkg.sv
// Shared types and constants for the wiggle sort interleave block.
`timescale 1ns / 1ps

package wsi_pkg;

    localparam int MAX_COUNT  = 64;
    localparam int VALUE_BITS = 16;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int HALF_COUNT = MAX_COUNT / 2;
    localparam int Q_DEPTH    = 2;
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
    localparam int QPTR_W     = $clog2(Q_DEPTH);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        value_t value;
        logic   is_final;
    } item_t;

    typedef struct packed {
        logic   insert;
        logic   pop;
        value_t value;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SPLIT,
        ST_EMIT
    } back_state_t;

endpackage

// File: hdl/wsi_front.sv
// Input side: accepts items and holds them in a short queue for the back end.
`timescale 1ns / 1ps

module wsi_front import wsi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] s_tdata,
    input  logic                  s_tlast,
    output logic                  q_valid,
    output item_t                 q_item,
    input  logic                  q_pop
);

    item_t             entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;

    assign s_tready = (fill_reg != QCNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= '{value: value_t'(s_tdata), is_final: s_tlast};
        end
    end

endmodule

// File: hdl/wsi_cells.sv
// Sorted cell chain: keeps the list in descending order, largest at the head.
`timescale 1ns / 1ps

module wsi_cells import wsi_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  count_t    count,
    output value_t    head
);

    value_t cell_reg  [MAX_COUNT];
    value_t cell_next [MAX_COUNT];
    logic   ins [MAX_COUNT];

    assign head = cell_reg[0];

    // A cell takes part in the insertion when it is empty or smaller than the new value.
    always_comb begin
        for (int k = 0; k < MAX_COUNT; k++) begin
            ins[k] = (CNT_W'(k) >= count) || (cell_reg[k] < cmd.value);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_COUNT; k++) begin
            cell_next[k] = cell_reg[k];
            if (cmd.insert) begin
                if (ins[k]) begin
                    if (k == 0) begin
                        cell_next[k] = cmd.value;
                    end else if (!ins[k-1]) begin
                        cell_next[k] = cmd.value;
                    end else begin
                        cell_next[k] = cell_reg[k-1];
                    end
                end
            end else if (cmd.pop && (k < MAX_COUNT - 1)) begin
                cell_next[k] = cell_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_COUNT; k++) begin
            cell_reg[k] <= cell_next[k];
        end
    end

endmodule

// File: hdl/wsi_back.sv
// Back end: sorts queued items into the cell chain and emits each list in wiggle order.
`timescale 1ns / 1ps

module wsi_back import wsi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  item_t                 q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_BITS-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    back_state_t state_reg, state_next;
    count_t      count_reg, count_next;
    count_t      half_reg, half_next;
    count_t      upper_cnt_reg, upper_cnt_next;
    count_t      remain_reg, remain_next;
    logic        drop_reg, drop_next;
    logic        odd_reg, odd_next;
    logic        out_valid_reg, out_valid_next;
    value_t      out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;
    logic        out_ovf_reg, out_ovf_next;
    value_t      upper_reg [HALF_COUNT];
    cell_cmd_t   cmd;
    value_t      head;
    logic        out_free;
    logic        upper_write;
    logic        upper_shift;
    logic        room;

    wsi_cells u_cells (
        .aclk  (aclk),
        .cmd   (cmd),
        .count (count_reg),
        .head  (head)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign room     = (count_reg < CNT_W'(MAX_COUNT));
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        half_next      = half_reg;
        upper_cnt_next = upper_cnt_reg;
        remain_next    = remain_reg;
        drop_next      = drop_reg;
        odd_next       = odd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        cmd            = '{insert: 1'b0, pop: 1'b0, value: q_item.value};
        q_pop          = 1'b0;
        upper_write    = 1'b0;
        upper_shift    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd.insert = room;
                    count_next = room ? count_reg + CNT_W'(1) : count_reg;
                    drop_next  = drop_reg || !room;
                    if (q_item.is_final) begin
                        half_next      = count_next >> 1;
                        remain_next    = count_next;
                        upper_cnt_next = '0;
                        odd_next       = 1'b0;
                        state_next     = ((count_next >> 1) != '0) ? ST_SPLIT : ST_EMIT;
                    end
                end
            end
            ST_SPLIT: begin
                // Park the upper half of the list, largest first.
                cmd.pop        = 1'b1;
                upper_write    = 1'b1;
                upper_cnt_next = upper_cnt_reg + CNT_W'(1);
                if (upper_cnt_next == half_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = (remain_reg == CNT_W'(1));
                    out_ovf_next   = drop_reg;
                    if (odd_reg) begin
                        out_value_next = upper_reg[0];
                        upper_shift    = 1'b1;
                    end else begin
                        out_value_next = head;
                        cmd.pop        = 1'b1;
                    end
                    odd_next    = !odd_reg;
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            half_reg      <= '0;
            upper_cnt_reg <= '0;
            remain_reg    <= '0;
            odd_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            upper_cnt_reg <= upper_cnt_next;
            remain_reg    <= remain_next;
            odd_reg       <= odd_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Upper half buffer: filled at the running count, drained from entry zero.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < HALF_COUNT; k++) begin
            if (upper_write && (upper_cnt_reg == CNT_W'(k))) begin
                upper_reg[k] <= head;
            end else if (upper_shift && (k < HALF_COUNT - 1)) begin
                upper_reg[k] <= upper_reg[k+1];
            end
        end
    end

endmodule

// File: hdl/wiggle_sort_interleave.sv
// Top level of the wiggle sort interleave block.
// Each input item puts one signed value into a sorted chain of 64 cells;
// the item marked tlast closes the list. A closed list of n values then
// parks its floor(n/2) largest values as its upper half and is emitted, one item
// per cycle while m_tready is high.
// The single insert per cycle into the cell chain and the one output register
// set this pace. A two-entry input queue keeps s_tready high while a list
// is being emitted until it fills. Values beyond 64 are dropped and tuser is
// set on every result of that list.
`timescale 1ns / 1ps

module wiggle_sort_interleave import wsi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] s_tdata,   // [15:0] value
    input  logic                  s_tlast,   // is_final
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_BITS-1:0] m_tdata,   // [15:0] out_value
    output logic                  m_tlast,   // out_final
    output logic                  m_tuser    // [0] overflow
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    wsi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    wsi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/wsi_checker.sv
// Port-level checker for the wiggle sort interleave block, bound to the top level.
`timescale 1ns / 1ps

module wsi_checker import wsi_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [VALUE_BITS-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    logic [3:0] open_lists_reg, open_lists_next;
    logic       in_list_reg;
    logic       list_ovf_reg;
    logic       in_last;
    logic       out_last;

    assign in_last  = s_tvalid && s_tready && s_tlast;
    assign out_last = m_tvalid && m_tready && m_tlast;

    always_comb begin
        open_lists_next = open_lists_reg;
        if (in_last && !out_last) begin
            open_lists_next = open_lists_reg + 4'd1;
        end else if (out_last && !in_last) begin
            open_lists_next = open_lists_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_lists_reg <= '0;
            in_list_reg    <= 1'b0;
        end else begin
            open_lists_reg <= open_lists_next;
            if (m_tvalid && m_tready) begin
                in_list_reg <= !m_tlast;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            list_ovf_reg <= m_tuser;
        end
    end

    // The output register is empty the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // Results only appear for a list whose closing item has been taken.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_lists_reg != 4'd0)
        else $error("result before its list was closed");

    // The overflow flag is the same on every result of one list.
    a_ovf_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && in_list_reg |-> m_tuser == list_ovf_reg)
        else $error("overflow flag changed within a list");

endmodule

bind wiggle_sort_interleave wsi_checker u_wsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: verif/tb_wiggle_sort_interleave.sv
// Testbench for wiggle_sort_interleave: random lists under stalls, checked against a wiggle-order scoreboard.
`timescale 1ns / 1ps

module tb_wiggle_sort_interleave;
    import wsi_pkg::*;

    typedef struct {
        value_t value;
        logic   last;
        logic   ovf;
    } wiggle_result_t;

    class wiggle_tracker;
        value_t         list_vals[MAX_COUNT];
        int             list_len;
        bit             dropped;
        wiggle_result_t pending_results[$];
        int             errors;

        function new();
            list_len = 0;
            dropped  = 1'b0;
            errors   = 0;
        endfunction

        // Collects one accepted input item; a closing item queues the whole list
        // in wiggle order.
        function void take_value(value_t v, bit last);
            value_t         sorted[MAX_COUNT];
            value_t         key;
            wiggle_result_t res;
            int             j;
            int             lo;
            int             hi;
            if (list_len < MAX_COUNT) begin
                list_vals[list_len] = v;
                list_len++;
            end else begin
                dropped = 1'b1;
            end
            if (!last || list_len == 0) return;
            for (int i = 0; i < list_len; i++) sorted[i] = list_vals[i];
            for (int i = 1; i < list_len; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            lo = (list_len - 1) / 2;
            hi = list_len - 1;
            for (int i = 0; i < list_len; i++) begin
                if (i % 2 == 1) begin
                    res.value = sorted[hi];
                    hi--;
                end else begin
                    res.value = sorted[lo];
                    lo--;
                end
                res.last = (i == list_len - 1);
                res.ovf  = dropped;
                pending_results.push_back(res);
            end
            list_len = 0;
            dropped  = 1'b0;
        endfunction

        function void check_result(value_t v, logic last, logic ovf);
            wiggle_result_t exp_res;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: value %0d", v);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (v !== exp_res.value) begin
                $error("out_value expected %0d got %0d", exp_res.value, v);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("out_final expected %0b got %0b", exp_res.last, last);
                errors++;
            end
            if (ovf !== exp_res.ovf) begin
                $error("overflow expected %0b got %0b", exp_res.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [VALUE_BITS-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    wiggle_tracker tracker = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int items_sent;

    wiggle_sort_interleave dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("FAIL wiggle_sort_interleave");
        $finish;
    end

    // Result side: check accepted items, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(value_t'(m_tdata), m_tlast, m_tuser);
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_value(input value_t v, input bit last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_value(v, last);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending_results.size() > 0) @(posedge aclk);
    endtask

    task automatic send_queue(input value_t vals[$]);
        foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return value_t'(16'h7FFF);
            1:       return value_t'(16'h8000);
            2, 3:    return value_t'($urandom_range(0, 8) - 4);
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_random_list(input int len);
        for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
    endtask

    // Lists of one to twelve items, a quarter of them one to three items long to stress the turnaround.
    task automatic run_phase(input int s_idle, input int r_stall, input int n_items);
        int start;
        idle_pct  = s_idle;
        stall_pct = r_stall;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 3) == 0) send_random_list($urandom_range(1, 3));
            else send_random_list($urandom_range(1, 12));
        end
        stop_sending();
        wait_drained();
    endtask

    initial begin
        items_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lists: single extremes, a pair, duplicates, reversed order.
        send_queue('{value_t'(16'h7FFF)});
        send_queue('{value_t'(16'h8000)});
        send_queue('{value_t'(5), value_t'(-3)});
        send_queue('{value_t'(1), value_t'(2), value_t'(3)});
        send_queue('{value_t'(-1), value_t'(0), value_t'(1), value_t'(16'h8000),
                     value_t'(16'h7FFF)});
        send_queue('{value_t'(7), value_t'(7), value_t'(7), value_t'(7)});
        send_queue('{value_t'(60), value_t'(50), value_t'(40), value_t'(-40),
                     value_t'(-50), value_t'(-60)});
        stop_sending();
        wait_drained();

        // Capacity: an exactly full list, then one whose tail and closing item
        // are dropped.
        send_random_list(MAX_COUNT);
        send_random_list(MAX_COUNT + 2);
        stop_sending();
        wait_drained();

        // Long receiver hold-off while the sender keeps offering lists.
        hold_left <= 400;
        for (int k = 0; k < 4; k++) send_random_list(10);
        stop_sending();
        wait_drained();

        run_phase(0, 0, 20);
        run_phase(63, 0, 20);
        run_phase(0, 63, 20);
        run_phase(38, 38, 20);
        send_random_list($urandom_range(MAX_COUNT + 1, MAX_COUNT + 6));
        stop_sending();
        wait_drained();

        repeat (100) @(posedge aclk);
        if (tracker.pending_results.size() > 0) begin
            $error("%0d expected result items never arrived",
                   tracker.pending_results.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("PASS wiggle_sort_interleave");
        end else begin
            $display("FAIL wiggle_sort_interleave");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/wsi_pkg.sv
hdl/wsi_front.sv
hdl/wsi_cells.sv
hdl/wsi_back.sv
hdl/wiggle_sort_interleave.sv
hdl/wsi_checker.sv
verif/tb_wiggle_sort_interleave.sv
